// ===== hdl/bmhq_pkg.sv =====
// types and codes shared by the binary min-heap queue
// no dependencies
`timescale 1ns / 1ps

package bmhq_pkg;

    // default number of heap entries
    localparam int unsigned CAPACITY_DEF = 64;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // request word
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] priority_req;
        logic [31:0]        payload;
    } req_t;

    // response word
    typedef struct packed {
        logic [31:0] popped_payload;
        logic [1:0]  status;
    } rsp_t;

    // one stored heap entry
    typedef struct packed {
        logic signed [31:0] prio;
        logic [31:0]        pay;
    } entry_t;

endpackage

// ===== hdl/binary_min_heap_queue_core.sv =====
// binary min-heap priority queue core: sequencer around one two-read-port heap memory
// depends on bmhq_pkg
`timescale 1ns / 1ps
// a push walks up from the new leaf, reading the parent and then comparing and writing back
// per level, until it reaches the root or stops below; a pop loads the root and last entry,
// then walks down, reading both children and then comparing and writing back per level
// throughput: one word at a time, no new word accepted until its response is loaded;
// a stalled response holds off the next word
// reset: asynchronous active-low rst_n empties the heap (entry count to zero); memory not cleared

module binary_min_heap_queue_core #(
    parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bmhq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bmhq_pkg::rsp_t rsp
);

    // index width, count width, and a child index width wide enough for 2*pos+2
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_RESULT
    } state_t;

    state_t state_reg;

    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      par_reg;
    logic [XW-1:0]      child_reg;
    bmhq_pkg::entry_t   mover_reg;
    bmhq_pkg::rsp_t     res_reg;
    bmhq_pkg::rsp_t     rsp_reg;
    logic               rsp_valid_reg;

    // heap memory, two synchronous read ports and one write port
    bmhq_pkg::entry_t   heap_mem [CAPACITY];
    bmhq_pkg::entry_t   rd_a_reg;
    bmhq_pkg::entry_t   rd_b_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    bmhq_pkg::entry_t   wr_data;
    logic [AW-1:0]      rd_a_addr;
    logic [AW-1:0]      rd_b_addr;

    logic               accept;
    logic [XW-1:0]      child_idx;
    logic [XW-1:0]      count_x;
    logic               right_ok;
    logic               take_right;
    bmhq_pkg::entry_t   chosen;
    logic [XW-1:0]      chosen_idx;
    logic               out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // sift-down child selection: right child wins a tie
    assign child_idx  = {1'b0, pos_reg, 1'b0} + XW'(1);
    assign count_x    = XW'(count_reg);
    assign right_ok   = (child_reg + XW'(1)) < count_x;
    assign take_right = right_ok && (rd_b_reg.prio <= rd_a_reg.prio);
    assign chosen     = take_right ? rd_b_reg : rd_a_reg;
    assign chosen_idx = take_right ? (child_reg + XW'(1)) : child_reg;

    // memory port control
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = mover_reg;
        rd_a_addr = par_reg;
        rd_b_addr = par_reg;
        case (state_reg)
            S_IDLE:
            begin
                // pop fetches root and last entry together
                rd_a_addr = '0;
                rd_b_addr = AW'(count_reg - CW'(1));
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en = 1'b1;
                end
                rd_a_addr = (pos_reg - AW'(1)) >> 1;
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (!(rd_a_reg.prio <= mover_reg.prio))
                begin
                    wr_data = rd_a_reg;
                end
            end
            S_DN_RD:
            begin
                if (child_idx >= count_x)
                begin
                    wr_en = 1'b1;
                end
                rd_a_addr = child_idx[AW-1:0];
                rd_b_addr = AW'(child_idx + XW'(1));
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (!(mover_reg.prio <= chosen.prio))
                begin
                    wr_data = chosen;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    // sequencer, entry count and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            par_reg       <= '0;
            child_reg     <= '0;
            mover_reg     <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // output register: loaded from the result state, cleared once taken
            if (state_reg == S_RESULT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_reg.popped_payload <= '0;
                        if (req.opcode == bmhq_pkg::OP_PUSH)
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                // full: word dropped
                                res_reg.status <= bmhq_pkg::ST_FULL;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                res_reg.status <= bmhq_pkg::ST_OK;
                                pos_reg        <= count_reg[AW-1:0];
                                count_reg      <= count_reg + CW'(1);
                                mover_reg.prio <= req.priority_req;
                                mover_reg.pay  <= req.payload;
                                state_reg      <= S_UP_RD;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                res_reg.status <= bmhq_pkg::ST_EMPTY;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                res_reg.status <= bmhq_pkg::ST_OK;
                                count_reg      <= count_reg - CW'(1);
                                state_reg      <= S_POP_LD;
                            end
                        end
                    end
                end
                S_UP_RD:
                begin
                    // at the root the mover is written this cycle
                    if (pos_reg == '0)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        par_reg   <= (pos_reg - AW'(1)) >> 1;
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP:
                begin
                    if (rd_a_reg.prio <= mover_reg.prio)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        pos_reg   <= par_reg;
                        state_reg <= S_UP_RD;
                    end
                end
                S_POP_LD:
                begin
                    res_reg.popped_payload <= rd_a_reg.pay;
                    mover_reg              <= rd_b_reg;
                    pos_reg                <= '0;
                    state_reg              <= S_DN_RD;
                end
                S_DN_RD:
                begin
                    if (child_idx >= count_x)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        child_reg <= child_idx;
                        state_reg <= S_DN_CMP;
                    end
                end
                S_DN_CMP:
                begin
                    if (mover_reg.prio <= chosen.prio)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        pos_reg   <= chosen_idx[AW-1:0];
                        state_reg <= S_DN_RD;
                    end
                end
                S_RESULT:
                begin
                    // wait for the output register to free up
                    if (out_free)
                    begin
                        rsp_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // entry count stays within the heap
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // writes land inside the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < CAPACITY))
        else $error("heap write out of range");

    // an accepted push into a heap with room grows it by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == bmhq_pkg::OP_PUSH && count_reg != CW'(CAPACITY))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow heap");

    // only a successful pop carries a payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != bmhq_pkg::ST_OK) |-> (rsp_reg.popped_payload == '0))
        else $error("error response with payload");

    // a response is loaded only when the output register was free
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> $stable(rsp_reg))
        else $error("stalled response overwritten");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for binary_min_heap_queue_core: directed and random push/pop words
// depends on bmhq_pkg and the core; keeps its own heap shadow to predict every response
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned DEPTH        = bmhq_pkg::CAPACITY_DEF;
    // cycles with no word moving on either side before the run is declared hung
    localparam int unsigned STUCK_LIMIT  = 2000;
    // quiet cycles after the last response, more than the slowest word needs
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned PHASE_WORDS  = 312;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    bmhq_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    bmhq_pkg::rsp_t rsp;

    // shadow of the heap contents and fill level
    bmhq_pkg::entry_t shadow_heap [DEPTH];
    int unsigned      shadow_fill = 0;

    // responses predicted but not yet seen, oldest first
    bmhq_pkg::rsp_t   awaited_answers [$];
    bmhq_pkg::rsp_t   oldest_answer;

    // idling controls, percent per cycle
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int unsigned fail_count   = 0;
    int unsigned stuck_cycles = 0;
    int unsigned push_count   = 0;
    int unsigned pop_count    = 0;
    int unsigned full_count   = 0;
    int unsigned empty_count  = 0;

    binary_min_heap_queue_core #(
        .CAPACITY (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // heap predictor: applies one word to the shadow heap and returns
    // the response the core should give for it
    // ------------------------------------------------------------------
    function automatic bit prio_not_above(input bmhq_pkg::entry_t a, input bmhq_pkg::entry_t b);
        return $signed(a.prio) <= $signed(b.prio);
    endfunction

    function automatic bmhq_pkg::rsp_t heap_answer(input bmhq_pkg::req_t w);
        bmhq_pkg::rsp_t   r;
        bmhq_pkg::entry_t mover;
        int unsigned      pos;
        int unsigned      parent;
        int unsigned      child;
        r = '0;
        r.status = bmhq_pkg::ST_OK;
        if (w.opcode == bmhq_pkg::OP_PUSH)
        begin
            if (shadow_fill >= DEPTH)
            begin
                // full heap: word dropped, contents untouched
                r.status = bmhq_pkg::ST_FULL;
            end
            else
            begin
                mover.prio  = w.priority_req;
                mover.pay   = w.payload;
                pos         = shadow_fill;
                shadow_fill = shadow_fill + 1;
                // sift up, equal priorities never overtake
                while (pos != 0)
                begin
                    parent = (pos - 1) / 2;
                    if (prio_not_above(shadow_heap[parent], mover))
                        break;
                    shadow_heap[pos] = shadow_heap[parent];
                    pos = parent;
                end
                shadow_heap[pos] = mover;
            end
        end
        else
        begin
            if (shadow_fill == 0)
            begin
                r.status = bmhq_pkg::ST_EMPTY;
            end
            else
            begin
                r.popped_payload = shadow_heap[0].pay;
                shadow_fill      = shadow_fill - 1;
                mover            = shadow_heap[shadow_fill];
                pos              = 0;
                child            = 1;
                // sift down: right child wins a tie, mover stays on a tie
                while (child < shadow_fill)
                begin
                    if (child + 1 < shadow_fill &&
                        prio_not_above(shadow_heap[child + 1], shadow_heap[child]))
                        child = child + 1;
                    if (prio_not_above(mover, shadow_heap[child]))
                        break;
                    shadow_heap[pos] = shadow_heap[child];
                    pos   = child;
                    child = 2 * pos + 1;
                end
                shadow_heap[pos] = mover;
            end
        end
        return r;
    endfunction

    // random word; priorities are often drawn from a narrow band so ties are common
    function automatic bmhq_pkg::req_t random_word(input int unsigned push_pct);
        bmhq_pkg::req_t w;
        w.opcode = ($urandom_range(99) < push_pct) ? bmhq_pkg::OP_PUSH : bmhq_pkg::OP_POP;
        if ($urandom_range(1) == 0)
            w.priority_req = $urandom;
        else
            w.priority_req = $signed($urandom_range(7)) - 4;
        w.payload = $urandom;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // request side: called and returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_word(input bmhq_pkg::req_t w);
        bmhq_pkg::rsp_t r;
        // random gap before the word, valid held low meanwhile
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        // word taken at this edge: predict its response
        r = heap_answer(w);
        awaited_answers.push_back(r);
        if (w.opcode == bmhq_pkg::OP_PUSH)
            push_count++;
        else
            pop_count++;
        if (r.status == bmhq_pkg::ST_FULL)
            full_count++;
        if (r.status == bmhq_pkg::ST_EMPTY)
            empty_count++;
        @(negedge clk);
    endtask

    task automatic send_op(input logic op, input logic [31:0] prio, input logic [31:0] pay);
        bmhq_pkg::req_t w;
        w.opcode       = op;
        w.priority_req = prio;
        w.payload      = pay;
        send_word(w);
    endtask

    // sender holds off until every predicted response has come back
    task automatic drain_answers;
        req_valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(input int unsigned idle, input int unsigned stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty pops, extreme priorities and payloads, a run of equal priorities
    task automatic test_extremes_and_ties;
        send_op(bmhq_pkg::OP_POP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(bmhq_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_op(bmhq_pkg::OP_PUSH, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(bmhq_pkg::OP_PUSH, 32'h0000_0000, 32'hA5A5_A5A5);
        send_op(bmhq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        // equal priorities: order out shows the tie rules on both sifts
        send_op(bmhq_pkg::OP_PUSH, 32'd7, 32'd1);
        send_op(bmhq_pkg::OP_PUSH, 32'd7, 32'd2);
        send_op(bmhq_pkg::OP_PUSH, 32'd7, 32'd3);
        send_op(bmhq_pkg::OP_PUSH, 32'd7, 32'd4);
        repeat (8)
            send_op(bmhq_pkg::OP_POP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(bmhq_pkg::OP_POP, 32'h7FFF_FFFF, 32'h8000_0000);
        drain_answers();
    endtask

    // fill to the brim, push into a full heap, then empty it again
    task automatic test_fill_to_capacity;
        repeat (DEPTH)
            send_word(random_word(100));
        repeat (3)
            send_word(random_word(100));
        // hold off here: the core must settle with a full heap
        drain_answers();
        repeat (DEPTH)
            send_word(random_word(0));
        send_word(random_word(0));
        drain_answers();
    endtask

    // bursts leaning to push or pop so the heap swings between empty and full
    task automatic test_random_traffic(input int unsigned count);
        int unsigned left;
        int unsigned burst;
        int unsigned push_pct;
        left = count;
        while (left != 0)
        begin
            burst = $urandom_range(80, 8);
            if (burst > left)
                burst = left;
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            repeat (burst)
                send_word(random_word(push_pct));
            left = left - burst;
        end
        drain_answers();
    endtask

    // ------------------------------------------------------------------
    // response side: random stall, driven at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_answers.size() == 0)
            begin
                $error("unexpected response word: popped_payload %h status %0d",
                       rsp.popped_payload, rsp.status);
                fail_count++;
            end
            else
            begin
                oldest_answer = awaited_answers.pop_front();
                if (rsp.popped_payload !== oldest_answer.popped_payload)
                begin
                    $error("popped_payload: expected %h, got %h",
                           oldest_answer.popped_payload, rsp.popped_payload);
                    fail_count++;
                end
                if (rsp.status !== oldest_answer.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_answer.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without a word moving on either side
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("** binary_min_heap_queue_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_extremes_and_ties();
        set_idling(14, 14);
        test_fill_to_capacity();

        // four idling phases: none, slow sender, slow receiver, both a little
        set_idling(0, 0);
        test_random_traffic(PHASE_WORDS);
        set_idling(82, 0);
        test_random_traffic(PHASE_WORDS);
        set_idling(0, 82);
        test_random_traffic(PHASE_WORDS);
        set_idling(14, 14);
        test_random_traffic(PHASE_WORDS);

        // any stray response would show up here
        set_idling(0, 0);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("covered %0d pushes (%0d dropped on a full heap) and %0d pops (%0d on empty)",
                 push_count, full_count, pop_count, empty_count);
        $display("under four idling mixes, with ties and extreme priorities; %0d mismatches",
                 fail_count);
        if (fail_count == 0)
            $display("** binary_min_heap_queue_core: PASSED **");
        else
            $display("** binary_min_heap_queue_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bmhq_pkg.sv
hdl/binary_min_heap_queue_core.sv
bench/testbench.sv
